/* hdl/swa_pkg.sv */
// ----------------------------------------------------------------------------
// swa_pkg: shared types and constants for the sample window averager
// Holds the sample type and the fixed widths and reset value of the
// window length register.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int WIN_LEN_W     = 5;
    localparam int WIN_LEN_RESET = 16;

    typedef logic [SAMPLE_W-1:0]  t_sample;
    typedef logic [WIN_LEN_W-1:0] t_win_len;

endpackage

/* hdl/swa_sample_if.sv */
// ----------------------------------------------------------------------------
// swa_sample_if: input sample channel
// Valid/ready channel that moves one unsigned 16-bit sample per request.
// ----------------------------------------------------------------------------
interface swa_sample_if;

    logic             valid;
    logic             ready;
    swa_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

/* hdl/swa_result_if.sv */
// ----------------------------------------------------------------------------
// swa_result_if: result channel
// Valid/ready channel that moves the latest sample and the window mean.
// ----------------------------------------------------------------------------
interface swa_result_if;

    logic             valid;
    logic             ready;
    swa_pkg::t_sample current_value;
    swa_pkg::t_sample average_value;

    modport source (output valid, output current_value, output average_value, input ready);
    modport sink   (input valid, input current_value, input average_value, output ready);

endinterface

/* hdl/sample_window_averager.sv */
// One sample is handled at a time: a new sample is taken only in idle, once
// the previous result has gone to the output register. L being the effective
// window length, the single add/subtract unit first sums the L ring entries
// one entry a cycle, then runs a 16-step divide.
// Reset (synchronous, active low) clears the control state, the primed flag
// and sets the window length to 16; the ring is filled by the first sample.
// ----------------------------------------------------------------------------
// sample_window_averager: moving average over a ring of recent samples
// Stores samples in a ring memory, sums the active window through a shared
// adder and divides the sum by the window length with a restoring divider.
// ----------------------------------------------------------------------------
module sample_window_averager #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  swa_pkg::t_win_len   i_cfg_wdata,
    swa_sample_if.sink          i_smp,
    swa_result_if.source        o_res
);
    import swa_pkg::*;

    localparam int LENW = $clog2(WINDOW_MAX + 1);
    localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNTW = (LENW > 4) ? LENW : 4;
    localparam int SUMW = SAMPLE_W + LENW;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FILL    = 3'd1;
    localparam logic [2:0] S_WRITE   = 3'd2;
    localparam logic [2:0] S_SUM     = 3'd3;
    localparam logic [2:0] S_DIVINIT = 3'd4;
    localparam logic [2:0] S_DIV     = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]      r_state, n_state;
    t_win_len        r_win_len, n_win_len;
    logic            r_primed, n_primed;
    logic [AW-1:0]   r_wr_idx, n_wr_idx;
    logic [CNTW-1:0] r_cnt, n_cnt;
    t_sample         r_sample, n_sample;
    logic [SUMW-1:0] r_acc, n_acc;
    logic [LENW-1:0] r_rem, n_rem;
    t_sample         r_quo, n_quo;
    logic            r_rd_vld, n_rd_vld;
    logic            r_out_vld, n_out_vld;
    t_sample         r_out_cur, n_out_cur;
    t_sample         r_out_avg, n_out_avg;

    t_sample         r_ring [WINDOW_MAX];
    t_sample         r_rd_data;

    logic [LENW-1:0] w_len;
    logic [AW-1:0]   w_wr_addr;
    logic [AW:0]     w_idx_inc;
    logic            w_mem_we;
    logic [AW-1:0]   w_mem_waddr;
    logic            w_mem_re;

    logic [SUMW-1:0] w_alu_a;
    logic [SUMW-1:0] w_alu_b;
    logic            w_alu_sub;
    logic [SUMW:0]   w_alu_res;
    logic [LENW:0]   w_div_pr;

    // Length 0 counts as 1, and anything above the ring size as the ring size.
    always_comb begin
        if (r_win_len == '0) begin
            w_len = LENW'(1);
        end else if (32'(r_win_len) > WINDOW_MAX) begin
            w_len = LENW'(WINDOW_MAX);
        end else begin
            w_len = LENW'(r_win_len);
        end
    end

    // The index restarts at zero when the window length is no longer above it.
    assign w_wr_addr = (32'(r_wr_idx) >= 32'(w_len)) ? '0 : r_wr_idx;
    assign w_idx_inc = {1'b0, w_wr_addr} + (AW+1)'(1);

    // Partial remainder with the next dividend bit shifted in.
    assign w_div_pr = {r_rem, r_quo[SAMPLE_W-1]};

    // Shared add/subtract unit: accumulates in the sum phase, trial
    // subtracts in the divide phase.
    always_comb begin
        w_alu_a   = r_acc;
        w_alu_b   = SUMW'(r_rd_data);
        w_alu_sub = 1'b0;
        if (r_state == S_DIV) begin
            w_alu_a   = SUMW'(w_div_pr);
            w_alu_b   = SUMW'(w_len);
            w_alu_sub = 1'b1;
        end
        if (w_alu_sub) begin
            w_alu_res = {1'b0, w_alu_a} - {1'b0, w_alu_b};
        end else begin
            w_alu_res = {1'b0, w_alu_a} + {1'b0, w_alu_b};
        end
    end

    assign i_smp.ready         = (r_state == S_IDLE);
    assign o_res.valid         = r_out_vld;
    assign o_res.current_value = r_out_cur;
    assign o_res.average_value = r_out_avg;

    always_comb begin
        n_state   = r_state;
        n_win_len = r_win_len;
        n_primed  = r_primed;
        n_wr_idx  = r_wr_idx;
        n_cnt     = r_cnt;
        n_sample  = r_sample;
        n_acc     = r_acc;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_rd_vld  = 1'b0;
        n_out_vld = r_out_vld;
        n_out_cur = r_out_cur;
        n_out_avg = r_out_avg;
        w_mem_we    = 1'b0;
        w_mem_waddr = w_wr_addr;
        w_mem_re    = 1'b0;

        if (i_cfg_we) begin
            n_win_len = i_cfg_wdata;
        end
        if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_smp.valid) begin
                    n_sample = i_smp.sample;
                    n_cnt    = '0;
                    n_state  = r_primed ? S_WRITE : S_FILL;
                end
            end
            S_FILL: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_cnt[AW-1:0];
                n_cnt       = r_cnt + CNTW'(1);
                if (32'(r_cnt) == WINDOW_MAX - 1) begin
                    n_wr_idx = '0;
                    n_primed = 1'b1;
                    n_cnt    = '0;
                    n_acc    = '0;
                    n_state  = S_SUM;
                end
            end
            S_WRITE: begin
                w_mem_we = 1'b1;
                if (32'(w_idx_inc) >= 32'(w_len)) begin
                    n_wr_idx = '0;
                end else begin
                    n_wr_idx = w_idx_inc[AW-1:0];
                end
                n_cnt   = '0;
                n_acc   = '0;
                n_state = S_SUM;
            end
            S_SUM: begin
                // Read data arrives in the cycle after its address.
                if (r_rd_vld) begin
                    n_acc = w_alu_res[SUMW-1:0];
                end
                if (32'(r_cnt) < 32'(w_len)) begin
                    w_mem_re = 1'b1;
                    n_rd_vld = 1'b1;
                    n_cnt    = r_cnt + CNTW'(1);
                end else begin
                    n_state = S_DIVINIT;
                end
            end
            S_DIVINIT: begin
                // The sum is below 65536 times the length, so its upper bits
                // already form a valid partial remainder.
                n_rem   = r_acc[SUMW-1:SAMPLE_W];
                n_quo   = r_acc[SAMPLE_W-1:0];
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_alu_res[SUMW]) begin
                    n_rem = w_div_pr[LENW-1:0];
                    n_quo = {r_quo[SAMPLE_W-2:0], 1'b0};
                end else begin
                    n_rem = w_alu_res[LENW-1:0];
                    n_quo = {r_quo[SAMPLE_W-2:0], 1'b1};
                end
                n_cnt = r_cnt + CNTW'(1);
                if (32'(r_cnt) == SAMPLE_W - 1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_res.ready) begin
                    n_out_vld = 1'b1;
                    n_out_cur = r_sample;
                    n_out_avg = r_quo;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_win_len <= t_win_len'(WIN_LEN_RESET);
            r_primed  <= 1'b0;
            r_wr_idx  <= '0;
            r_cnt     <= '0;
            r_sample  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_win_len <= n_win_len;
            r_primed  <= n_primed;
            r_wr_idx  <= n_wr_idx;
            r_cnt     <= n_cnt;
            r_sample  <= n_sample;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_out_cur <= n_out_cur;
        r_out_avg <= n_out_avg;
    end

    // Sample ring: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_ring[w_mem_waddr] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_re) begin
            r_rd_data <= r_ring[r_cnt[AW-1:0]];
        end
    end

    a_busy_not_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_smp.ready)
        else $error("input ready while a sample is in progress");

    a_accept_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> (r_state == S_FILL || r_state == S_WRITE))
        else $error("accepted sample did not start a ring update");

    a_primed_sticks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_primed) |-> r_primed)
        else $error("primed flag dropped without reset");

    a_div_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVINIT) |-> (32'(r_acc[SUMW-1:SAMPLE_W]) < 32'(w_len)))
        else $error("window sum too large for a 16-bit quotient");

    a_wr_idx_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |-> (32'(r_wr_idx) < 32'(w_len)))
        else $error("write index outside the window after an update");

endmodule
